@@ hdl/cm6_pkg.sv @@
// ----------------------------------------------------------------------------
// cm6_pkg
// Shared types, constants and the character mapping of the six-bit text
// sample decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package cm6_pkg;

  localparam int MAX_LEVELS_DEF = 3;

  localparam int CHAR_W   = 8;
  localparam int SAMPLE_W = 32;
  localparam int COUNT_W  = 24;
  localparam int LEVELS_W = 2;
  localparam int CODE_W   = 6;

  // Character values that steer the decoder.
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;

  // Bits of a six-bit code.
  localparam int SIGN_POS = 4;
  localparam int MORE_POS = 5;

  // Configuration register indexes.
  localparam logic REG_DIFF_LEVELS = 1'b0;
  localparam logic REG_MAX_SAMPLES = 1'b1;

  localparam logic [LEVELS_W-1:0] DIFF_LEVELS_RST = 2'd2;
  localparam logic [COUNT_W-1:0]  MAX_SAMPLES_RST = {COUNT_W{1'b1}};

  // One result item as it moves down the chain.
  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic                frame_end;
    logic [COUNT_W-1:0]  count;
  } item_t;

  // Maps the low seven bits of a byte to its six-bit code.
  function automatic logic [CODE_W-1:0] map_code(input logic [CHAR_W-1:0] byte_in);
    logic [6:0] c;
    logic [6:0] code7;
    c     = byte_in[6:0];
    code7 = 7'd0;
    if (c == 7'd43) begin
      code7 = 7'd0;
    end else if (c == 7'd45) begin
      code7 = 7'd1;
    end else if (c >= 7'd48 && c <= 7'd57) begin
      code7 = c - 7'd46;
    end else if (c >= 7'd65 && c <= 7'd90) begin
      code7 = c - 7'd53;
    end else if (c >= 7'd97 && c <= 7'd122) begin
      code7 = c - 7'd59;
    end
    return code7[CODE_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ hdl/cm6_decode.sv @@
// ----------------------------------------------------------------------------
// cm6_decode
// Front stage: maps characters to codes, assembles samples, applies the sign,
// counts samples and enforces the frame limit.
// ----------------------------------------------------------------------------
`default_nettype none

module cm6_decode (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         en,
  input  wire logic                         char_valid,
  input  wire logic [cm6_pkg::CHAR_W-1:0]   char_code,
  input  wire logic [cm6_pkg::COUNT_W-1:0]  max_samples,
  output logic                              item_valid,
  output cm6_pkg::item_t                    item
);
  import cm6_pkg::*;

  logic [SAMPLE_W-1:0] partial_r, partial_nxt, partial_upd;
  logic                neg_r, neg_nxt, neg_eff;
  logic                cont_r, cont_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt, count_inc;
  logic                limit_r, limit_nxt;
  logic                valid_r, valid_nxt;
  item_t               item_r, item_nxt;
  logic [CODE_W-1:0]   code;
  logic [SAMPLE_W-1:0] signed_val;

  assign code        = map_code(char_code);
  assign partial_upd = cont_r ? ({partial_r[SAMPLE_W-6:0], 5'b0} + {27'b0, code[4:0]})
                              : {28'b0, code[3:0]};
  assign neg_eff     = cont_r ? neg_r : code[SIGN_POS];
  assign signed_val  = neg_eff ? (32'd0 - partial_upd) : partial_upd;
  assign count_inc   = count_r + 24'd1;

  always_comb begin
    partial_nxt = partial_r;
    neg_nxt     = neg_r;
    cont_nxt    = cont_r;
    count_nxt   = count_r;
    limit_nxt   = limit_r;
    valid_nxt   = 1'b0;
    item_nxt    = item_r;
    if (char_valid) begin
      priority if (char_code == CH_CR || char_code == CH_LF) begin
        valid_nxt = 1'b0;
      end else if (!cont_r && char_code == CH_SPACE) begin
        valid_nxt          = 1'b1;
        item_nxt.value     = '0;
        item_nxt.frame_end = 1'b1;
        item_nxt.count     = count_r;
        partial_nxt        = '0;
        neg_nxt            = 1'b0;
        count_nxt          = '0;
        limit_nxt          = 1'b0;
      end else if (limit_r) begin
        valid_nxt = 1'b0;
      end else if (code[MORE_POS]) begin
        cont_nxt    = 1'b1;
        partial_nxt = partial_upd;
        neg_nxt     = neg_eff;
      end else begin
        cont_nxt           = 1'b0;
        partial_nxt        = '0;
        neg_nxt            = 1'b0;
        count_nxt          = count_inc;
        limit_nxt          = (count_inc >= max_samples);
        valid_nxt          = 1'b1;
        item_nxt.value     = signed_val;
        item_nxt.frame_end = 1'b0;
        item_nxt.count     = count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      neg_r     <= 1'b0;
      cont_r    <= 1'b0;
      count_r   <= '0;
      limit_r   <= 1'b0;
      valid_r   <= 1'b0;
    end else if (en) begin
      partial_r <= partial_nxt;
      neg_r     <= neg_nxt;
      cont_r    <= cont_nxt;
      count_r   <= count_nxt;
      limit_r   <= limit_nxt;
      valid_r   <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= item_nxt;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

@@ hdl/cm6_cell.sv @@
// ----------------------------------------------------------------------------
// cm6_cell
// One running-sum cell of the integrator chain. It holds one sum and hands
// the integrated item to its neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module cm6_cell #(
  parameter int IDX = 0
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic [cm6_pkg::LEVELS_W-1:0]  diff_levels,
  input  wire logic                          in_valid,
  input  wire cm6_pkg::item_t                in_item,
  output logic                               out_valid,
  output cm6_pkg::item_t                     out_item
);
  import cm6_pkg::*;

  localparam logic [3:0] IDX_W = 4'(IDX);

  logic [SAMPLE_W-1:0] sum_r, sum_nxt;
  logic                valid_r;
  item_t               item_r, item_nxt;
  logic                active;

  // The cell takes part only when its place is below the configured depth.
  assign active = IDX_W < {2'b00, diff_levels};

  always_comb begin
    sum_nxt  = sum_r;
    item_nxt = in_item;
    if (in_valid) begin
      if (in_item.frame_end) begin
        sum_nxt = '0;
      end else if (active) begin
        sum_nxt        = sum_r + in_item.value;
        item_nxt.value = sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      valid_r <= 1'b0;
    end else if (en) begin
      sum_r   <= sum_nxt;
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

`default_nettype wire

@@ hdl/cm6_skid.sv @@
// ----------------------------------------------------------------------------
// cm6_skid
// Output register with a skid entry, so the chain's enable is a register
// and does not follow the downstream ready.
// ----------------------------------------------------------------------------
`default_nettype none

module cm6_skid (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire cm6_pkg::item_t  in_item,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output cm6_pkg::item_t       out_item
);
  import cm6_pkg::*;

  logic  main_valid_r, skid_valid_r;
  item_t main_item_r, skid_item_r;
  logic  take;

  assign in_ready = !skid_valid_r;
  assign take     = in_valid && !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_ready || !main_valid_r) begin
      if (skid_valid_r) begin
        main_valid_r <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        main_valid_r <= take;
      end
    end else if (take) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !main_valid_r) begin
      main_item_r <= skid_valid_r ? skid_item_r : in_item;
    end else if (take) begin
      skid_item_r <= in_item;
    end
  end

  assign out_valid = main_valid_r;
  assign out_item  = main_item_r;

endmodule

`default_nettype wire

@@ hdl/cm6_decode_with_integration_unit.sv @@
// From an accepted character to its result item, the path is registered in the
// decode stage, one stage per running-sum cell and the output register.
// Throughput: one character per cycle; the chain advances whenever the output
// skid entry is free, and CR, LF and continuation characters give no item.
// Reset (rst_n, synchronous, active low) clears all decode state, sums and counts,
// and loads diff_levels = 2 and max_samples = 16777215.
// ----------------------------------------------------------------------------
// cm6_decode_with_integration_unit
// Six-bit text sample decoder followed by a chain of running-sum cells that
// undo difference coding, with a frame end marker on a space between samples.
// ----------------------------------------------------------------------------
`default_nettype none

module cm6_decode_with_integration_unit #(
  parameter int MAX_LEVELS = cm6_pkg::MAX_LEVELS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Input channel: tdata = char_code[7:0].
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [cm6_pkg::CHAR_W-1:0]    in_tdata,
  // Result channel: tdata = sample[31:0], sample_count[55:32]; tlast = frame_end.
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [55:0]                        out_tdata,
  output logic                               out_tlast,
  // Configuration: index 0 is diff_levels, index 1 is max_samples.
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic                          cfg_index,
  input  wire logic [cm6_pkg::COUNT_W-1:0]   cfg_data
);
  import cm6_pkg::*;

  logic [LEVELS_W-1:0] diff_levels_r;
  logic [COUNT_W-1:0]  max_samples_r;

  // The whole chain moves on one enable, which is the registered ready of
  // the output skid stage. Bubbles travel along with the items.
  logic  chain_en;
  logic  stage_valid [MAX_LEVELS+1];
  item_t stage_item  [MAX_LEVELS+1];
  item_t res_item;

  // Configuration is always accepted; writes are expected only while idle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diff_levels_r <= DIFF_LEVELS_RST;
      max_samples_r <= MAX_SAMPLES_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DIFF_LEVELS: diff_levels_r <= cfg_data[LEVELS_W-1:0];
        REG_MAX_SAMPLES: max_samples_r <= cfg_data;
        default:         diff_levels_r <= diff_levels_r;
      endcase
    end
  end

  assign in_tready = chain_en;

  // Front stage: character decode, sign, sample count and frame limit.
  cm6_decode u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (chain_en),
    .char_valid  (in_tvalid),
    .char_code   (in_tdata),
    .max_samples (max_samples_r),
    .item_valid  (stage_valid[0]),
    .item        (stage_item[0])
  );

  // Running-sum cells. A cell at or beyond the configured depth passes its
  // item through unchanged, which also covers depths above MAX_LEVELS. A frame
  // end marker clears each sum as it passes, so ordering against samples
  // before and after it is kept.
  for (genvar k = 0; k < MAX_LEVELS; k++) begin : g_cell
    cm6_cell #(
      .IDX (k)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .en          (chain_en),
      .diff_levels (diff_levels_r),
      .in_valid    (stage_valid[k]),
      .in_item     (stage_item[k]),
      .out_valid   (stage_valid[k+1]),
      .out_item    (stage_item[k+1])
    );
  end

  // Output register with a skid entry between the chain and the consumer.
  cm6_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (stage_valid[MAX_LEVELS]),
    .in_ready  (chain_en),
    .in_item   (stage_item[MAX_LEVELS]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_item  (res_item)
  );

  assign out_tdata = {res_item.count, res_item.value};
  assign out_tlast = res_item.frame_end;

  // An end marker always carries a zero sample.
  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[31:0] == 32'd0)
    else $error("frame end item with nonzero sample");

  // A sample item always counts itself, so its count is never zero.
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[55:32] != 24'd0)
    else $error("sample item with zero count");

  // The chain is held only while the output register holds an item.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !chain_en |-> out_tvalid)
    else $error("chain stalled with empty output register");

  // While stalled, a waiting result item keeps its value.
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result item changed while stalled");

endmodule

`default_nettype wire

@@ verif/cm6_result_checker.sv @@
// ----------------------------------------------------------------------------
// cm6_result_checker
// Watches the character, result and register channels of the decoder. It keeps
// its own model of the decode and running-sum state, and checks every result
// item against the oldest expected one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cm6_result_checker #(
  parameter int NUM_STAGES = cm6_pkg::MAX_LEVELS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  input  wire logic                        in_tready,
  input  wire logic [cm6_pkg::CHAR_W-1:0]  in_tdata,
  input  wire logic                        out_tvalid,
  input  wire logic                        out_tready,
  input  wire logic [55:0]                 out_tdata,
  input  wire logic                        out_tlast,
  input  wire logic                        cfg_valid,
  input  wire logic                        cfg_ready,
  input  wire logic                        cfg_index,
  input  wire logic [cm6_pkg::COUNT_W-1:0] cfg_data,
  input  wire logic                        end_of_test,
  output int                               fail_count,
  output int                               pending_results,
  output int                               live_chars,
  output int                               chars_seen,
  output int                               results_seen
);

  import cm6_pkg::*;

  localparam int MAX_PRINTS = 60;

  // Register copies.
  logic [LEVELS_W-1:0] levels_cfg;
  logic [COUNT_W-1:0]  limit_cfg;

  // Decoder state.
  logic [SAMPLE_W-1:0] acc_value;
  logic                acc_neg;
  logic                in_sample;
  logic [SAMPLE_W-1:0] sums [NUM_STAGES];
  logic [COUNT_W-1:0]  frame_count;
  logic                at_limit;

  item_t expected_samples [$];
  bit    end_checked = 1'b0;

  initial begin
    fail_count      = 0;
    pending_results = 0;
    live_chars      = 0;
    chars_seen      = 0;
    results_seen    = 0;
  end

  task automatic flag_error(input string msg);
    if (fail_count < MAX_PRINTS) begin
      $display("ERROR at %0t ns: %s", $time, msg);
    end
    fail_count++;
  endtask

  function automatic logic [CODE_W-1:0] sym_code(input logic [CHAR_W-1:0] ch);
    logic [7:0] a;
    a = {1'b0, ch[6:0]};
    if (a >= "a" && a <= "z") return CODE_W'(a - "a" + 8'd38);
    if (a >= "A" && a <= "Z") return CODE_W'(a - "A" + 8'd12);
    if (a >= "0" && a <= "9") return CODE_W'(a - "0" + 8'd2);
    if (a == "-") return CODE_W'(1);
    return '0;
  endfunction

  task automatic clear_frame();
    acc_value   = '0;
    acc_neg     = 1'b0;
    in_sample   = 1'b0;
    frame_count = '0;
    at_limit    = 1'b0;
    for (int k = 0; k < NUM_STAGES; k++) sums[k] = '0;
  endtask

  task automatic decode_char(input logic [CHAR_W-1:0] ch);
    logic [CODE_W-1:0]   code;
    logic [SAMPLE_W-1:0] v;
    int                  n;
    item_t               exp_item;
    if (ch == CH_CR || ch == CH_LF) return;
    // A space between samples closes the frame, even past the limit.
    if (!in_sample && ch == CH_SPACE) begin
      exp_item.value     = '0;
      exp_item.frame_end = 1'b1;
      exp_item.count     = frame_count;
      expected_samples.push_back(exp_item);
      clear_frame();
      live_chars++;
      return;
    end
    if (at_limit) return;
    live_chars++;
    code = sym_code(ch);
    if (!in_sample) begin
      acc_neg   = code[SIGN_POS];
      acc_value = SAMPLE_W'(code[3:0]);
    end else begin
      acc_value = (acc_value << 5) + SAMPLE_W'(code[4:0]);
    end
    if (code[MORE_POS]) begin
      in_sample = 1'b1;
      return;
    end
    in_sample = 1'b0;
    v = acc_neg ? -acc_value : acc_value;
    n = (int'(levels_cfg) > NUM_STAGES) ? NUM_STAGES : int'(levels_cfg);
    for (int k = 0; k < n; k++) begin
      sums[k] = sums[k] + v;
      v       = sums[k];
    end
    acc_value   = '0;
    acc_neg     = 1'b0;
    frame_count = frame_count + 1'b1;
    if (frame_count >= limit_cfg) at_limit = 1'b1;
    exp_item.value     = v;
    exp_item.frame_end = 1'b0;
    exp_item.count     = frame_count;
    expected_samples.push_back(exp_item);
  endtask

  task automatic check_result();
    item_t exp_item;
    results_seen++;
    if (expected_samples.size() == 0) begin
      flag_error($sformatf("result item with nothing expected: sample %0d last %0b count %0d",
                           $signed(out_tdata[31:0]), out_tlast, out_tdata[55:32]));
      return;
    end
    exp_item = expected_samples.pop_front();
    if (out_tdata[31:0] !== exp_item.value)
      flag_error($sformatf("sample %0d, expected %0d", $signed(out_tdata[31:0]),
                           $signed(exp_item.value)));
    if (out_tlast !== exp_item.frame_end)
      flag_error($sformatf("frame end %0b, expected %0b", out_tlast, exp_item.frame_end));
    if (out_tdata[55:32] !== exp_item.count)
      flag_error($sformatf("sample count %0d, expected %0d", out_tdata[55:32],
                           exp_item.count));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      levels_cfg = DIFF_LEVELS_RST;
      limit_cfg  = MAX_SAMPLES_RST;
      clear_frame();
      expected_samples.delete();
    end else begin
      if (out_tvalid && out_tready) check_result();
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_DIFF_LEVELS) levels_cfg = cfg_data[LEVELS_W-1:0];
        else                              limit_cfg  = cfg_data;
      end
      if (in_tvalid && in_tready) begin
        chars_seen++;
        decode_char(in_tdata);
      end
      if (end_of_test && !end_checked) begin
        end_checked = 1'b1;
        foreach (expected_samples[i])
          flag_error($sformatf("expected result never came: sample %0d last %0b count %0d",
                               $signed(expected_samples[i].value),
                               expected_samples[i].frame_end, expected_samples[i].count));
      end
    end
    pending_results = expected_samples.size();
  end

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the six-bit text sample decoder. A short directed
// run is followed by random frames under several register settings and
// several patterns of back-pressure; a separate checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  import cm6_pkg::*;

  // A character's result passes the decode, running-sum and output registers.
  localparam int PIPE_DEPTH  = MAX_LEVELS_DEF + 2;
  // Quiet cycles before a register write and at the end of the run.
  localparam int HOLD_CYCLES = 2 * PIPE_DEPTH + 4;
  // Cycles without any accepted item before the run is declared hung.
  localparam int STALL_LIMIT = 2000;
  // Characters sent per random phase.
  localparam int PHASE_CHARS = 250;
  localparam int NUM_PHASES  = 6;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_tvalid;
  wire logic            in_tready;
  logic [CHAR_W-1:0]    in_tdata;     // char_code[7:0]
  wire logic            out_tvalid;
  logic                 out_tready;
  wire logic [55:0]     out_tdata;    // sample[31:0], sample_count[55:32]
  wire logic            out_tlast;    // frame_end
  logic                 cfg_valid;
  wire logic            cfg_ready;
  logic                 cfg_index;
  logic [COUNT_W-1:0]   cfg_data;
  logic                 end_of_test;

  int fail_count;
  int pending_results;
  int live_chars;
  int chars_seen;
  int results_seen;

  // Percent of cycles in which the sender or the receiver holds off.
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int idle_cycles = 0;
  int settings_done = 0;

  always #5 clk = ~clk;

  cm6_decode_with_integration_unit #(
    .MAX_LEVELS (MAX_LEVELS_DEF)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  cm6_result_checker #(
    .NUM_STAGES (MAX_LEVELS_DEF)
  ) i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tlast       (out_tlast),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .end_of_test     (end_of_test),
    .fail_count      (fail_count),
    .pending_results (pending_results),
    .live_chars      (live_chars),
    .chars_seen      (chars_seen),
    .results_seen    (results_seen)
  );

  // The receiver draws its ready at every falling edge. With no idling it
  // simply stays high.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Watchdog: any accepted item on any channel restarts the count. The only
  // deliberate quiet stretches are the short hold-offs, far below the limit.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no item moved for %0d cycles.", STALL_LIMIT);
      $display("FAIL cm6_decode_with_integration_unit");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offers one character. The task is entered at a falling edge and returns
  // at the falling edge after the character was accepted, with valid still
  // high so that back-to-back characters never toggle it within one step.
  task automatic send_char(input logic [CHAR_W-1:0] ch);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // Turns a six-bit code back into one of the characters that carry it.
  function automatic logic [CHAR_W-1:0] code_to_char(input logic [CODE_W-1:0] code);
    logic [7:0] c;
    if (code == 6'd0)       c = "+";
    else if (code == 6'd1)  c = "-";
    else if (code < 6'd12)  c = "0" + 8'(code) - 8'd2;
    else if (code < 6'd38)  c = "A" + 8'(code) - 8'd12;
    else                    c = "a" + 8'(code) - 8'd38;
    return c;
  endfunction

  // Sends a code, with the ignored top bit of the byte set now and then.
  task automatic send_code(input logic [CODE_W-1:0] code);
    logic [CHAR_W-1:0] ch;
    ch = code_to_char(code);
    if ($urandom_range(3) == 0) ch[7] = 1'b1;
    send_char(ch);
  endtask

  // One well-formed sample: a head code with sign and four value bits, then
  // a number of continuation codes. Mostly short samples, a few that run far
  // past 32 bits. CR or LF may turn up between any two codes.
  task automatic send_sample();
    int                r;
    int                extra;
    logic [CODE_W-1:0] code;
    r = $urandom_range(99);
    if (r < 50)      extra = $urandom_range(1);
    else if (r < 90) extra = $urandom_range(4, 2);
    else             extra = $urandom_range(7, 5);
    for (int k = 0; k <= extra; k++) begin
      code = 6'($urandom);
      code[MORE_POS] = (k < extra);
      send_code(code);
      if ($urandom_range(99) < 4) send_char($urandom_range(1) ? CH_CR : CH_LF);
    end
  endtask

  // One random frame. Most are a run of samples closed by a space. The rest
  // are noise bytes, a space inside a sample that ends it but not the frame,
  // or a frame left open so that the next one runs on in the same count.
  task automatic send_frame();
    int r;
    int n;
    logic [CODE_W-1:0] code;
    r = $urandom_range(99);
    if (r < 7) begin
      n = $urandom_range(6, 1);
      repeat (n) send_char(CHAR_W'($urandom));
    end else begin
      n = $urandom_range(10);
      repeat (n) send_sample();
      r = $urandom_range(99);
      if (r < 6) begin
        code = 6'($urandom);
        code[MORE_POS] = 1'b1;
        send_code(code);
        send_char(CH_SPACE);
      end else if (r >= 10) begin
        send_char(CH_SPACE);
      end
    end
  endtask

  // Waits until every expected item has come back, then lets the chain drain
  // characters that gave no item. Entered and left at a falling edge.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (HOLD_CYCLES) @(negedge clk);
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last write.
  task automatic write_reg(input logic idx, input logic [COUNT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    int                  start_chars;
    logic [LEVELS_W-1:0] lv;
    logic [COUNT_W-1:0]  mx;

    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_DIFF_LEVELS;
    cfg_data    = '0;
    end_of_test = 1'b0;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed run at the reset settings (two running sums, no real limit).
    // An empty frame first, so the end marker carries a count of zero.
    send_char(CH_SPACE);
    // Plus and minus, the top digit, the lowest capital, and a negative
    // single-code sample.
    send_text("+-9AT");
    // A carriage return in the middle of a continued sample is skipped.
    send_text("Z");
    send_char(CH_CR);
    send_text("z");
    // A line feed inside a sample, then a space that completes the sample
    // instead of closing the frame.
    send_text("a");
    send_char(CH_LF);
    send_char(CH_SPACE);
    // Bytes of all ones and all zeros, then '+' and 'A' with the top bit set.
    send_char(8'hFF);
    send_char(8'h00);
    send_char(8'hAB);
    send_char(8'hC1);
    // A negative sample long enough to wrap the 32-bit value.
    send_text("zzzzzzz+");
    send_char(CH_SPACE);

    // Random phases. The first two idle the sender lightly and the receiver
    // heavily, the next two the other way round, the last two not at all.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin
          lv = 2'd0;
          mx = MAX_SAMPLES_RST;
        end
        1: begin
          lv = 2'd3;
          mx = 24'd1;
        end
        2: begin
          // A zero limit lets exactly one sample out per frame.
          lv = 2'd1;
          mx = 24'd0;
        end
        3: begin
          lv = 2'd3;
          mx = COUNT_W'($urandom_range(40, 2));
        end
        4: begin
          // A frame left open before this write may already be past the
          // new limit.
          lv = 2'd2;
          mx = 24'd3;
        end
        default: begin
          lv = LEVELS_W'($urandom);
          mx = COUNT_W'($urandom);
        end
      endcase
      settle();
      tx_idle_pct = (ph < 2) ? 36 : (ph < 4) ? 60 : 0;
      rx_idle_pct = (ph < 2) ? 60 : (ph < 4) ? 36 : 0;
      write_reg(REG_DIFF_LEVELS, COUNT_W'(lv));
      write_reg(REG_MAX_SAMPLES, mx);
      cfg_valid <= 1'b0;
      settings_done++;
      // Every accepted character counts toward the phase, ignored ones too.
      start_chars = chars_seen;
      while (chars_seen - start_chars < PHASE_CHARS) send_frame();
    end

    settle();
    end_of_test <= 1'b1;
    @(negedge clk);
    @(negedge clk);

    $display("Covered %0d characters (%0d decoded) and %0d result items over %0d settings,",
             chars_seen, live_chars, results_seen, settings_done + 1);
    $display("with back-pressure on each side in turn and a final stretch at full rate.");
    if (fail_count == 0) begin
      $display("PASS cm6_decode_with_integration_unit");
    end else begin
      $display("%0d mismatches.", fail_count);
      $display("FAIL cm6_decode_with_integration_unit");
    end
    $finish;
  end

endmodule
